// ===== hdl/pair_sum_index_finder_macros.svh =====
// Assertion macros shared by the pair sum index finder RTL.
`ifndef PAIR_SUM_INDEX_FINDER_MACROS_SVH
`define PAIR_SUM_INDEX_FINDER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PSIF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PSIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/psif_pkg.sv =====
// Shared types and constants of the pair sum index finder.
`default_nettype none

package psif_pkg;

    localparam int VAL_W             = 32;
    localparam int NEED_W            = VAL_W + 1;
    localparam int STATUS_W          = 2;
    localparam int IDX_FIELD_W       = 10;
    localparam int DEFAULT_MAX_ITEMS = 1024;

    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    // Broadcast from the controller to every cell of the store.
    typedef struct packed {
        logic              shift_en;
        logic [NEED_W-1:0] needed;
    } psif_query_t;

endpackage

`default_nettype wire

// ===== hdl/psif_cell.sv =====
// One store cell: holds a value, shifts it on, and compares it with the query.
`default_nettype none

module psif_cell
    import psif_pkg::*;
#(
    parameter int CNT_W = 11,
    parameter int POS   = 0
)(
    input  wire                  clk,
    input  wire psif_query_t     query,
    input  wire  [CNT_W-1:0]     count,
    input  wire  [VAL_W-1:0]     value_in,
    output logic [VAL_W-1:0]     value_out,
    output logic                 hit
);

    logic [VAL_W-1:0] value_reg;
    logic             hit_reg;

    // A cell only counts as filled when its position lies below the fill count.
    always_ff @(posedge clk)
    begin
        if (query.shift_en)
        begin
            value_reg <= value_in;
        end
        hit_reg <= (CNT_W'(POS) < count) &&
                   ({value_reg[VAL_W-1], value_reg} == query.needed);
    end

    assign value_out = value_reg;
    assign hit       = hit_reg;

endmodule

`default_nettype wire

// ===== hdl/psif_prio_tree.sv =====
// Registered priority tree that finds the lowest hit position among the cells.
`default_nettype none

module psif_prio_tree
#(
    parameter int MAX_ITEMS = 1024
)(
    input  wire                            clk,
    input  wire  [MAX_ITEMS-1:0]           hit,
    output logic                           root_any,
    output logic [$clog2(MAX_ITEMS)-1:0]   root_pos
);

    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int LEAVES = 1 << IDX_W;

    // Heap numbering: node n has children 2n and 2n+1, leaves sit above LEAVES-1.
    logic             any_w [1:2*LEAVES-1];
    logic [IDX_W-1:0] pos_w [1:2*LEAVES-1];

    for (genvar k = 0; k < LEAVES; k++)
    begin : g_leaf
        if (k < MAX_ITEMS)
        begin : g_real
            assign any_w[LEAVES+k] = hit[k];
        end
        else
        begin : g_pad
            assign any_w[LEAVES+k] = 1'b0;
        end
        assign pos_w[LEAVES+k] = IDX_W'(k);
    end

    for (genvar n = 1; n < LEAVES; n++)
    begin : g_node
        logic             any_reg;
        logic [IDX_W-1:0] pos_reg;

        // The lower position is the newer element, so the left child wins.
        always_ff @(posedge clk)
        begin
            any_reg <= any_w[2*n] | any_w[2*n+1];
            pos_reg <= any_w[2*n] ? pos_w[2*n] : pos_w[2*n+1];
        end

        assign any_w[n] = any_reg;
        assign pos_w[n] = pos_reg;
    end

    assign root_any = any_w[1];
    assign root_pos = pos_w[1];

endmodule

`default_nettype wire

// ===== hdl/pair_sum_index_finder.sv =====
// Top level of the pair sum index finder: control, store chain and result register.
//
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_stall    element_value, start_of_set, end_of_set
//  out      output     out_valid / out_stall  status, earlier_index, later_index
//  cfg      input      cfg_wr_en              cfg_wr_data (target_sum)
//
// An element that is ignored, or that arrives after the set has filled, is not looked up.
// An element that is looked up stalls the input in S_LOOK until its answer has passed the
// compare cells and the registered priority tree; a result then goes through S_EMIT into
// the output register. Reset clears the fill count and the flags
// at once, so no clearing pass is needed. A stalled output word holds, and the next
// element is still taken while it waits; only a second result waits behind it.
`default_nettype none

module pair_sum_index_finder
    import psif_pkg::*;
#(
    parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
)(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire signed [VAL_W-1:0]      cfg_wr_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire signed [VAL_W-1:0]      element_value,
    input  wire                         start_of_set,
    input  wire                         end_of_set,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [STATUS_W-1:0]         status,
    output logic [IDX_FIELD_W-1:0]      earlier_index,
    output logic [IDX_FIELD_W-1:0]      later_index
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    // Timer value at which the tree root holds the answer for the element under lookup.
    localparam int LAT   = IDX_W + 1;
    localparam int TMR_W = $clog2(LAT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // Control state.
    logic [1:0]             state_reg, state_next;
    logic [TMR_W-1:0]       timer_reg, timer_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   pair_done_reg, pair_done_next;
    logic                   ovf_reg, ovf_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] target_reg, target_next;

    // Payload held for the element under lookup and for the pending result.
    logic [NEED_W-1:0]      needed_reg, needed_next;
    logic [VAL_W-1:0]       cur_val_reg, cur_val_next;
    logic                   last_reg, last_next;
    logic [STATUS_W-1:0]    pend_status_reg, pend_status_next;
    logic [IDX_FIELD_W-1:0] pend_earlier_reg, pend_earlier_next;
    logic [IDX_FIELD_W-1:0] pend_later_reg, pend_later_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [IDX_FIELD_W-1:0] earlier_reg, earlier_next;
    logic [IDX_FIELD_W-1:0] later_reg, later_next;

    logic                   shift_en;
    psif_query_t            query;
    logic [VAL_W-1:0]       link [0:MAX_ITEMS-1];
    logic [MAX_ITEMS-1:0]   hit_vec;
    logic                   root_any;
    logic [IDX_W-1:0]       root_pos;

    logic [CNT_W-1:0]       eff_count;
    logic                   eff_done;
    logic                   eff_ovf;
    logic [CNT_W-1:0]       found_diff;
    logic                   slot_free;

    // A start mark clears the set's count and flags before the element is handled.
    assign eff_count  = start_of_set ? '0 : count_reg;
    assign eff_done   = start_of_set ? 1'b0 : pair_done_reg;
    assign eff_ovf    = start_of_set ? 1'b0 : ovf_reg;
    // The chain holds the newest element in cell 0, so position p is index count-1-p.
    assign found_diff = count_reg - CNT_W'(1) - CNT_W'(root_pos);
    assign slot_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        timer_next        = timer_reg;
        count_next        = count_reg;
        pair_done_next    = pair_done_reg;
        ovf_next          = ovf_reg;
        target_next       = cfg_wr_en ? cfg_wr_data : target_reg;
        needed_next       = needed_reg;
        cur_val_next      = cur_val_reg;
        last_next         = last_reg;
        pend_status_next  = pend_status_reg;
        pend_earlier_next = pend_earlier_reg;
        pend_later_next   = pend_later_reg;
        status_next       = status_reg;
        earlier_next      = earlier_reg;
        later_next        = later_reg;
        out_valid_next    = out_valid_reg && out_stall;
        shift_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    count_next     = eff_count;
                    pair_done_next = eff_done;
                    ovf_next       = eff_ovf;
                    if (!eff_done)
                    begin
                        if (eff_count == CNT_W'(MAX_ITEMS))
                        begin
                            // The set is full: the element is dropped and marks overflow.
                            ovf_next = 1'b1;
                            if (end_of_set)
                            begin
                                pend_status_next  = ST_OVER;
                                pend_earlier_next = '0;
                                pend_later_next   = '0;
                                state_next        = S_EMIT;
                            end
                        end
                        else
                        begin
                            // Exact sum: compare stored values with target minus element.
                            needed_next  = {target_reg[VAL_W-1], target_reg} -
                                           {element_value[VAL_W-1], element_value};
                            cur_val_next = element_value;
                            last_next    = end_of_set;
                            timer_next   = '0;
                            state_next   = S_LOOK;
                        end
                    end
                end
            end

            S_LOOK:
            begin
                if (timer_reg == TMR_W'(LAT))
                begin
                    if (root_any)
                    begin
                        pair_done_next    = 1'b1;
                        pend_status_next  = ST_FOUND;
                        pend_earlier_next = IDX_FIELD_W'(found_diff);
                        pend_later_next   = IDX_FIELD_W'(count_reg);
                        state_next        = S_EMIT;
                    end
                    else
                    begin
                        // No partner: push the element into the head of the chain.
                        shift_en   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (last_reg)
                        begin
                            pend_status_next  = ovf_reg ? ST_OVER : ST_NONE;
                            pend_earlier_next = '0;
                            pend_later_next   = '0;
                            state_next        = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    timer_next = timer_reg + TMR_W'(1);
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    status_next    = pend_status_reg;
                    earlier_next   = pend_earlier_reg;
                    later_next     = pend_later_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timer_reg     <= '0;
            count_reg     <= '0;
            pair_done_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            timer_reg     <= timer_next;
            count_reg     <= count_next;
            pair_done_reg <= pair_done_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        needed_reg       <= needed_next;
        cur_val_reg      <= cur_val_next;
        last_reg         <= last_next;
        pend_status_reg  <= pend_status_next;
        pend_earlier_reg <= pend_earlier_next;
        pend_later_reg   <= pend_later_next;
        status_reg       <= status_next;
        earlier_reg      <= earlier_next;
        later_reg        <= later_next;
    end

    // Every cell sees the same query; values move one cell down on each store.
    assign query.shift_en = shift_en;
    assign query.needed   = needed_reg;
    assign link[0]        = cur_val_reg;

    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        if (k < MAX_ITEMS - 1)
        begin : g_mid
            psif_cell #(
                .CNT_W (CNT_W),
                .POS   (k)
            ) u_cell (
                .clk       (clk),
                .query     (query),
                .count     (count_reg),
                .value_in  (link[k]),
                .value_out (link[k+1]),
                .hit       (hit_vec[k])
            );
        end
        else
        begin : g_end
            psif_cell #(
                .CNT_W (CNT_W),
                .POS   (k)
            ) u_cell (
                .clk       (clk),
                .query     (query),
                .count     (count_reg),
                .value_in  (link[k]),
                .value_out (),
                .hit       (hit_vec[k])
            );
        end
    end

    psif_prio_tree #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_tree (
        .clk      (clk),
        .hit      (hit_vec),
        .root_any (root_any),
        .root_pos (root_pos)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign earlier_index = earlier_reg;
    assign later_index   = later_reg;

`include "pair_sum_index_finder_macros.svh"

    `PSIF_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS), "fill count beyond capacity")
    `PSIF_ASSERT_IMP(a_found_filled, state_reg == S_LOOK && timer_reg == TMR_W'(LAT) && root_any, CNT_W'(root_pos) < count_reg, "match in an empty cell")
    `PSIF_ASSERT_NEXT(a_done_quiet, in_valid && !in_stall && !start_of_set && pair_done_reg, state_reg == S_IDLE, "element looked up after a pair was found")
    `PSIF_ASSERT_NEXT(a_emit_load, state_reg == S_EMIT && slot_free, out_valid_reg && state_reg == S_IDLE, "pending result not loaded")

endmodule

`default_nettype wire

// ===== tb/sv/tb_pair_sum_index_finder.sv =====
// Self-checking testbench for the pair sum index finder, with a built-in predictor.
`timescale 1ns / 100ps

module tb_pair_sum_index_finder;
    import psif_pkg::*;

    localparam int ITEM_CAP = DEFAULT_MAX_ITEMS;

    // A looked-up element passes the compare cells, the priority tree and the output register,
    // and this settle time is comfortably longer than any word can still be in flight.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_PHASE_WORDS = 100;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam longint SUM_MIN = -(longint'(1) << 31);
    localparam longint SUM_MAX = (longint'(1) << 31) - 1;

    // One input word: an element and its set marks.
    typedef struct {
        logic signed [VAL_W-1:0] value;
        bit first;
        bit last;
    } set_elem_t;

    // One output word: the outcome of a set.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_FIELD_W-1:0] earlier;
        logic [IDX_FIELD_W-1:0] later;
    } pair_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic signed [VAL_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [VAL_W-1:0] element_value = '0;
    logic start_of_set = 1'b0;
    logic end_of_set = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [IDX_FIELD_W-1:0] earlier_index;
    logic [IDX_FIELD_W-1:0] later_index;

    // Words waiting to be sent, and the reports the block still owes us.
    set_elem_t pending_elems[$];
    pair_report_t owed_reports[$];

    // Predictor state. Because the store is cleared at each set start and a repeated
    // value must resolve to its newest index, a map from value to newest index gives
    // the same answer as a backward scan over the stored entries.
    int unsigned newest_index[longint];
    int unsigned fill_count = 0;
    bit pair_seen = 1'b0;
    bit overflowed = 1'b0;
    logic signed [VAL_W-1:0] target_now = '0;

    int mismatch_count = 0;
    int cycle_count = 0;

    // Driver bookkeeping. word_taken is raised at the rising edge that accepts a word
    // and consumed by the driver on the following falling edge.
    bit word_taken = 1'b0;
    bit calm = 1'b0;
    int send_gap = 0;
    int stall_left = 0;

    pair_sum_index_finder #(
        .MAX_ITEMS(ITEM_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .element_value(element_value),
        .start_of_set(start_of_set),
        .end_of_set(end_of_set),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .earlier_index(earlier_index),
        .later_index(later_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out what one accepted word does to the set state and which report,
    // if any, it causes.
    task automatic find_pair(input logic signed [VAL_W-1:0] v, input bit first,
                             input bit last);
        longint partner;
        pair_report_t rep;
        if (first)
        begin
            newest_index.delete();
            fill_count = 0;
            pair_seen = 1'b0;
            overflowed = 1'b0;
        end
        // Once a pair is reported the rest of the set is dropped, its end included.
        if (pair_seen)
            return;
        if (fill_count >= ITEM_CAP)
        begin
            // The set has filled: the element is neither compared nor stored.
            overflowed = 1'b1;
        end
        else
        begin
            // The sum is exact, so the partner is computed in 64 bits and a
            // partner outside the 32-bit range simply never matches.
            partner = longint'(target_now) - longint'(v);
            if (newest_index.exists(partner))
            begin
                pair_seen = 1'b1;
                rep.status = ST_FOUND;
                rep.earlier = newest_index[partner][IDX_FIELD_W-1:0];
                rep.later = fill_count[IDX_FIELD_W-1:0];
                owed_reports = {owed_reports, rep};
                return;
            end
            newest_index[longint'(v)] = fill_count;
            fill_count++;
        end
        if (last)
        begin
            rep.status = overflowed ? ST_OVER : ST_NONE;
            rep.earlier = '0;
            rep.later = '0;
            owed_reports = {owed_reports, rep};
        end
    endtask

    // Monitor: samples both handshakes and the configuration port at the rising edge.
    // The output side is checked before the input side is predicted; a report can
    // never come out in the same cycle as the word that causes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (out_valid && !out_stall)
            begin
                if (owed_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected no report, got status=%0d earlier=%0d later=%0d",
                             $time, status, earlier_index, later_index);
                end
                else
                begin
                    if (status !== owed_reports[0].status)
                    begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, owed_reports[0].status, status);
                    end
                    if (earlier_index !== owed_reports[0].earlier)
                    begin
                        mismatch_count++;
                        $display("%0t: earlier_index expected %0d, got %0d",
                                 $time, owed_reports[0].earlier, earlier_index);
                    end
                    if (later_index !== owed_reports[0].later)
                    begin
                        mismatch_count++;
                        $display("%0t: later_index expected %0d, got %0d",
                                 $time, owed_reports[0].later, later_index);
                    end
                    void'(owed_reports.pop_front());
                end
            end
            if (in_valid && !in_stall)
            begin
                find_pair(element_value, start_of_set, end_of_set);
                word_taken = 1'b1;
            end
            if (cfg_wr_en)
                target_now = cfg_wr_data;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Input driver: holds a word until it is accepted, then either opens a short
    // random gap or presents the next pending word.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || word_taken)
            begin
                word_taken = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_elems.size() > 0)
                begin
                    element_value <= pending_elems[0].value;
                    start_of_set <= pending_elems[0].first;
                    end_of_set <= pending_elems[0].last;
                    in_valid <= 1'b1;
                    void'(pending_elems.pop_front());
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 6);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: random bursts, none in the calm phase.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_elem(input logic signed [VAL_W-1:0] v, input bit first,
                              input bit last);
        set_elem_t e;
        e.value = v;
        e.first = first;
        e.last = last;
        pending_elems = {pending_elems, e};
    endtask

    // Waits until every pending word has gone in and every report has come out,
    // then lets any word that causes no report work its way through the block.
    task automatic drain_block();
        while (pending_elems.size() != 0 || in_valid || owed_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_target(input logic signed [VAL_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random sets, mostly well formed so that lookups, matches and ends all happen.
    // Values lean toward partners of earlier elements, repeats, small numbers and
    // the range extremes; about one set in eight has its marks scrambled.
    task automatic queue_random_sets(input logic signed [VAL_W-1:0] goal, input int budget);
        int queued;
        int len;
        int pick;
        bit noisy;
        bit first;
        bit last;
        longint want;
        logic signed [VAL_W-1:0] v;
        logic signed [VAL_W-1:0] seen[$];
        queued = 0;
        while (queued < budget)
        begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            noisy = ($urandom_range(0, 7) == 0);
            seen.delete();
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30 && seen.size() > 0)
                begin
                    want = longint'(goal) - longint'(seen[$urandom_range(0, seen.size() - 1)]);
                    if (want >= SUM_MIN && want <= SUM_MAX)
                        v = want[VAL_W-1:0];
                    else
                        v = $urandom;
                end
                else if (pick < 40 && seen.size() > 0)
                begin
                    v = seen[$urandom_range(0, seen.size() - 1)];
                end
                else if (pick < 60)
                begin
                    v = $urandom_range(0, 16) - 8;
                end
                else if (pick < 70)
                begin
                    case ($urandom_range(0, 4))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = 0;
                        3: v = -1;
                        default: v = 1;
                    endcase
                end
                else
                begin
                    v = $urandom;
                end
                first = (i == 0);
                last = (i == len - 1);
                if (noisy)
                begin
                    first = first ^ ($urandom_range(0, 3) == 0);
                    last = last ^ ($urandom_range(0, 3) == 0);
                end
                queue_elem(v, first, last);
                seen = {seen, v};
                queued++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero target: lone element, plain pair, exact sum that would wrap to zero,
        // newest index of a repeated value, words ignored after a pair, a set that
        // carries on after its end, and a start in the middle of a set.
        write_target(0);
        queue_elem(0, 1, 1);
        queue_elem(5, 1, 0);
        queue_elem(-5, 0, 1);
        queue_elem(VAL_MIN, 1, 0);
        queue_elem(VAL_MIN, 0, 1);
        queue_elem(7, 1, 0);
        queue_elem(3, 0, 0);
        queue_elem(7, 0, 0);
        queue_elem(-7, 0, 1);
        queue_elem(2, 1, 0);
        queue_elem(-2, 0, 0);
        queue_elem(9, 0, 0);
        queue_elem(-9, 0, 1);
        queue_elem(4, 1, 1);
        queue_elem(-4, 0, 1);
        queue_elem(11, 1, 0);
        queue_elem(12, 0, 0);
        queue_elem(-11, 1, 1);
        drain_block();

        // Largest target, reached only with the largest element.
        write_target(VAL_MAX);
        queue_elem(0, 1, 0);
        queue_elem(VAL_MAX, 0, 1);
        drain_block();

        // Smallest target, plus a sum that only matches if it wraps.
        write_target(VAL_MIN);
        queue_elem(VAL_MIN, 1, 0);
        queue_elem(0, 0, 1);
        queue_elem(-1, 1, 0);
        queue_elem(VAL_MIN + 1, 0, 1);
        queue_elem(VAL_MAX, 1, 0);
        queue_elem(1, 0, 1);
        drain_block();

        write_target($urandom);
        queue_random_sets(target_now, RANDOM_PHASE_WORDS);
        drain_block();
        write_target(VAL_MIN);
        queue_random_sets(VAL_MIN, RANDOM_PHASE_WORDS);
        drain_block();
        write_target(VAL_MAX);
        queue_random_sets(VAL_MAX, RANDOM_PHASE_WORDS);
        drain_block();
        write_target($urandom_range(0, 20) - 10);
        queue_random_sets(target_now, RANDOM_PHASE_WORDS);
        drain_block();

        // Last phase runs with no gaps on either side.
        write_target(0);
        calm = 1'b1;
        queue_random_sets(0, RANDOM_PHASE_WORDS);
        drain_block();

        if (mismatch_count == 0 && owed_reports.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
